/* hdl/rgbhls_pkg.sv */
package rgbhls_pkg;

   localparam int unsigned COMP_W = 8;
   localparam int unsigned DEN_W = 9;
   localparam int unsigned QUO_W = 9;
   localparam int unsigned HSUM_W = 12;
   localparam int unsigned NUM_LANES = 4;
   localparam int unsigned LANE_SAT = 3;
   localparam logic [HSUM_W-1:0] SECTOR_G_OFS = 12'd512;
   localparam logic [HSUM_W-1:0] SECTOR_B_OFS = 12'd1024;
   localparam logic [9:0] DIV6_RECIP = 10'd683;
   localparam int unsigned DIV6_SHIFT = 12;
   localparam logic [COMP_W-1:0] SAT_MAX = 8'd255;

   typedef enum logic [1:0] {
      SEC_RED,
      SEC_GREEN,
      SEC_BLUE
   } sector_type;

   typedef struct packed {
      logic [DEN_W-1:0] rem;
      logic [QUO_W-1:0] quo;
      logic [DEN_W-1:0] den;
   } div_lane_type;

   // The numerator is a * 256 with a <= den, so the top quotient bit is a == den.
   function automatic div_lane_type div_init(logic [DEN_W-1:0] a, logic [DEN_W-1:0] den);
      div_lane_type o;
      o.den = den;
      if (a == den) begin
         o.rem = '0;
         o.quo = QUO_W'(1);
      end else begin
         o.rem = a;
         o.quo = '0;
      end
      return o;
   endfunction

   function automatic div_lane_type div_step(div_lane_type l);
      div_lane_type o;
      logic [DEN_W:0] r2;
      o = l;
      r2 = {l.rem, 1'b0};
      if (r2 >= {1'b0, l.den}) begin
         o.rem = DEN_W'(r2 - {1'b0, l.den});
         o.quo = {l.quo[QUO_W-2:0], 1'b1};
      end else begin
         o.rem = r2[DEN_W-1:0];
         o.quo = {l.quo[QUO_W-2:0], 1'b0};
      end
      return o;
   endfunction

endpackage

/* hdl/rgb_to_hls_converter_core.sv */
// An accepted input beat passes the registers s1 to s5 to its output beat.
// Throughput: one pixel per cycle when not stalled by rsp_tready; four restoring
// dividers are spread over three stages that resolve two, three and three
// quotient bits after the first-bit setup, which sets the pipeline depth.
// Reset is synchronous and active high and clears all stage valid bits.
module rgb_to_hls_converter_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // red [7:0], green [15:8], blue [23:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // hue [7:0], lightness [15:8], saturation [23:16]
);
   import rgbhls_pkg::*;

   typedef struct packed {
      logic [COMP_W-1:0] r;
      logic [COMP_W-1:0] g;
      logic [COMP_W-1:0] b;
      logic [COMP_W-1:0] mx;
      logic [COMP_W-1:0] mn;
      sector_type        sector;
   } st1_type;

   typedef struct packed {
      div_lane_type [NUM_LANES-1:0] lanes;
      sector_type                   sector;
      logic                         grey;
      logic [COMP_W-1:0]            light;
   } stdiv_type;

   typedef struct packed {
      logic [HSUM_W-1:0] hsum;
      logic [COMP_W-1:0] sat;
      logic [COMP_W-1:0] light;
      logic              grey;
   } st4_type;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic adv1, adv2, adv3, adv4, adv5;
   st1_type s1_ff, s1_in;
   stdiv_type s2_ff, s2_in, s3_ff, s3_in;
   st4_type s4_ff, s4_in;
   logic [23:0] s5_ff, s5_in;

   assign adv5 = !v5_ff || rsp_tready;
   assign adv4 = !v4_ff || adv5;
   assign adv3 = !v3_ff || adv4;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;
   assign req_tready = adv1;
   assign rsp_tvalid = v5_ff;
   assign rsp_tdata = s5_ff;

   always_comb begin
      logic [COMP_W-1:0] r, g, b, mx, mn;
      r = req_tdata[7:0];
      g = req_tdata[15:8];
      b = req_tdata[23:16];
      mx = r;
      mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      s1_in.r = r;
      s1_in.g = g;
      s1_in.b = b;
      s1_in.mx = mx;
      s1_in.mn = mn;
      if (r == mx) s1_in.sector = SEC_RED;
      else if (g == mx) s1_in.sector = SEC_GREEN;
      else s1_in.sector = SEC_BLUE;
   end

   always_comb begin
      logic [COMP_W-1:0] spread;
      logic [COMP_W:0] sum;
      logic [DEN_W-1:0] sden;
      spread = s1_ff.mx - s1_ff.mn;
      sum = {1'b0, s1_ff.mx} + {1'b0, s1_ff.mn};
      if (!sum[COMP_W]) sden = sum;
      else sden = DEN_W'(10'd512 - {1'b0, sum});
      s2_in.sector = s1_ff.sector;
      s2_in.grey = (spread == '0);
      s2_in.light = sum[COMP_W:1];
      s2_in.lanes[0] = div_init({1'b0, s1_ff.mx - s1_ff.r}, {1'b0, spread});
      s2_in.lanes[1] = div_init({1'b0, s1_ff.mx - s1_ff.g}, {1'b0, spread});
      s2_in.lanes[2] = div_init({1'b0, s1_ff.mx - s1_ff.b}, {1'b0, spread});
      s2_in.lanes[LANE_SAT] = div_init({1'b0, spread}, sden);
      for (int i = 0; i < NUM_LANES; i++) begin
         s2_in.lanes[i] = div_step(div_step(s2_in.lanes[i]));
      end
   end

   always_comb begin
      s3_in = s2_ff;
      for (int i = 0; i < NUM_LANES; i++) begin
         s3_in.lanes[i] = div_step(div_step(div_step(s2_ff.lanes[i])));
      end
   end

   always_comb begin
      div_lane_type [NUM_LANES-1:0] ln;
      logic [HSUM_W-1:0] rc, gc, bc;
      for (int i = 0; i < NUM_LANES; i++) begin
         ln[i] = div_step(div_step(div_step(s3_ff.lanes[i])));
      end
      rc = HSUM_W'(ln[0].quo);
      gc = HSUM_W'(ln[1].quo);
      bc = HSUM_W'(ln[2].quo);
      case (s3_ff.sector)
         SEC_RED:   s4_in.hsum = bc - gc;
         SEC_GREEN: s4_in.hsum = SECTOR_G_OFS + rc - bc;
         SEC_BLUE:  s4_in.hsum = SECTOR_B_OFS + gc - rc;
         default:   s4_in.hsum = '0;
      endcase
      s4_in.sat = ln[LANE_SAT].quo[QUO_W-1] ? SAT_MAX : ln[LANE_SAT].quo[COMP_W-1:0];
      s4_in.light = s3_ff.light;
      s4_in.grey = s3_ff.grey;
   end

   always_comb begin
      logic neg;
      logic [10:0] mag;
      logic [20:0] prod;
      logic [COMP_W-1:0] q, hue;
      neg = s4_ff.hsum[HSUM_W-1];
      mag = neg ? 11'(-s4_ff.hsum) : s4_ff.hsum[10:0];
      prod = 21'(mag) * 21'(DIV6_RECIP);
      q = prod[DIV6_SHIFT+COMP_W-1:DIV6_SHIFT];
      if (s4_ff.grey) hue = '0;
      else if (neg) hue = -q;
      else hue = q;
      s5_in = {s4_ff.grey ? 8'd0 : s4_ff.sat, s4_ff.light, hue};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= req_tvalid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
         if (adv4) v4_ff <= v3_ff;
         if (adv5) v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) s1_ff <= s1_in;
      if (adv2) s2_ff <= s2_in;
      if (adv3) s3_ff <= s3_in;
      if (adv4) s4_ff <= s4_in;
      if (adv5) s5_ff <= s5_in;
   end

endmodule

/* hdl/rgbhls_checker.sv */
module rgbhls_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   // A result beat that is not taken stays in place.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result beat changed");

   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // With the output side open the pipeline never holds back the input.
   assert property (@(posedge clock) disable iff (reset) rsp_tready |-> req_tready)
      else $error("input stalled while output ready");

   // Zero saturation only comes from a grey pixel, which has hue zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[23:16] == 8'd0 |-> rsp_tdata[7:0] == 8'd0)
      else $error("grey result with nonzero hue");

endmodule

bind rgb_to_hls_converter_core rgbhls_checker u_rgbhls_checker (
   .clock(clock),
   .reset(reset),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata)
);
